FILE: sv/hbr_pkg.sv
// hbr_pkg: shared types and constants of the HMM backward recursion block.
// No dependencies; all but the interfaces and checker use it by scoped names.
package hbr_pkg;

  // request codes of an input beat
  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_START = 2'd1,
    REQ_EMIT  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  // configuration register indexes
  localparam logic CFG_NUM_STATES = 1'b0;
  localparam logic CFG_SCALING    = 1'b1;

  localparam logic [6:0]  NUM_STATES_RST = 7'd8;
  localparam logic [31:0] SAT32          = 32'hFFFF_FFFF;
  localparam int unsigned SUM_W          = 39;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;

  // back-end sequencer states
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ISSUE = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_PUT   = 5'b10000
  } state_e;

  // classified request handed from front to back
  typedef struct packed {
    req_e        cmd;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [16:0] prob;
    logic [31:0] scale;
    logic [6:0]  n;
    logic        scale_en;
    logic        fin;
  } entry_t;

endpackage

FILE: sv/hbr_req_if.sv
// hbr_req_if: input request channel, valid/ready with payload.
// Depends on nothing.
interface hbr_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [5:0]  row_index;
  logic [5:0]  col_index;
  logic [16:0] prob_value;
  logic [31:0] scale_value;

  modport source (output valid, req_type, row_index, col_index, prob_value, scale_value,
                  input ready);
  modport sink   (input valid, req_type, row_index, col_index, prob_value, scale_value,
                  output ready);
endinterface

FILE: sv/hbr_rsp_if.sv
// hbr_rsp_if: result channel, valid/ready with payload.
// Depends on nothing.
interface hbr_rsp_if;
  logic        valid;
  logic        ready;
  logic [5:0]  state_index;
  logic [31:0] beta_value;
  logic [31:0] prob_sum;
  logic        last;

  modport source (output valid, state_index, beta_value, prob_sum, last, input ready);
  modport sink   (input valid, state_index, beta_value, prob_sum, last, output ready);
endinterface

FILE: sv/hbr_front.sv
// hbr_front: accepts request beats, drops the ones without effect, tags the rest.
// Depends on hbr_pkg and hbr_req_if.
module hbr_front #(
  parameter int unsigned MAX_STATES = 8
) (
  hbr_req_if.sink          req,
  input  logic [6:0]       num_states_i,
  input  logic             scaling_i,
  input  logic             full_i,
  output logic             push_o,
  output hbr_pkg::entry_t  entry_o
);

  logic [6:0] n;
  logic       keep;

  // clamp the state count into 1..MAX_STATES
  always_comb begin
    if (num_states_i == 7'd0) begin
      n = 7'd1;
    end else if (num_states_i > 7'(MAX_STATES)) begin
      n = 7'(MAX_STATES);
    end else begin
      n = num_states_i;
    end
  end

  // classify the beat
  always_comb begin
    unique case (hbr_pkg::req_e'(req.req_type))
      hbr_pkg::REQ_LOAD:  keep = ({1'b0, req.row_index} < 7'(MAX_STATES)) &&
                                 ({1'b0, req.col_index} < 7'(MAX_STATES));
      hbr_pkg::REQ_START: keep = 1'b1;
      hbr_pkg::REQ_EMIT:  keep = {1'b0, req.col_index} < n;
      hbr_pkg::REQ_NONE:  keep = 1'b0;
      default:            keep = 1'b0;
    endcase
  end

  assign req.ready = !full_i;
  assign push_o    = req.valid && !full_i && keep;

  assign entry_o.cmd      = hbr_pkg::req_e'(req.req_type);
  assign entry_o.row      = req.row_index;
  assign entry_o.col      = req.col_index;
  assign entry_o.prob     = req.prob_value;
  assign entry_o.scale    = req.scale_value;
  assign entry_o.n        = n;
  assign entry_o.scale_en = scaling_i;
  assign entry_o.fin      = ({1'b0, req.col_index} == (n - 7'd1));

endmodule

FILE: sv/hbr_fifo.sv
// hbr_fifo: short queue of classified requests between front and back.
// Depends on hbr_pkg.
module hbr_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hbr_pkg::entry_t  din_i,
  output logic             full_o,
  input  logic             pop_i,
  output hbr_pkg::entry_t  dout_o,
  output logic             empty_o
);

  hbr_pkg::entry_t                  mem_q [hbr_pkg::QUEUE_DEPTH];
  logic [hbr_pkg::QPTR_W-1:0]       wr_q, rd_q;
  logic [hbr_pkg::QPTR_W:0]         cnt_q;

  assign full_o  = (cnt_q == (hbr_pkg::QPTR_W+1)'(hbr_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign dout_o  = mem_q[rd_q];

  // store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= din_i;
    end
  end

  // advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: sv/hbr_div.sv
// hbr_div: fixed-point divider, floor(num * 2^FRAC_BITS / den) saturated to 32 bits.
// One quotient bit per cycle; overflow and zero divisor finish at once.
module hbr_div #(
  parameter int unsigned ACC_W     = 38,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ACC_W-1:0] num_i,
  input  logic [31:0]      den_i,
  output logic             done_o,
  output logic [31:0]      quo_o
);

  localparam int unsigned DW   = ACC_W + FRAC_BITS;
  localparam int unsigned HI_W = DW - 32;
  localparam int unsigned CW   = (HI_W > 32) ? HI_W : 32;

  logic [DW-1:0]   dvd;
  logic [HI_W-1:0] hi;
  logic            ovf;
  logic [31:0]     rem_q, lo_q, den_q, quo_q;
  logic [5:0]      cnt_q;
  logic            busy_q, done_q;
  logic [32:0]     r2;
  logic            qbit;

  assign dvd = DW'(num_i) << FRAC_BITS;
  assign hi  = dvd[DW-1:32];
  assign ovf = (den_i == 32'd0) || (CW'(hi) >= CW'(den_i));

  assign r2   = {rem_q, lo_q[31]};
  assign qbit = (r2 >= {1'b0, den_q});

  assign done_o = done_q;
  assign quo_o  = quo_q;

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= 32'(hi);
      lo_q  <= dvd[31:0];
      den_q <= den_i;
      quo_q <= ovf ? hbr_pkg::SAT32 : 32'd0;
    end else if (busy_q) begin
      rem_q <= qbit ? 32'(r2 - {1'b0, den_q}) : r2[31:0];
      lo_q  <= {lo_q[30:0], 1'b0};
      quo_q <= {quo_q[30:0], qbit};
    end
  end

  // step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= !ovf;
        done_q <= ovf;
        cnt_q  <= 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/hbr_back.sv
// hbr_back: executes queued requests: stores, multiply-accumulate pipeline,
// divider sequencing and the result register. Depends on hbr_pkg, hbr_div, hbr_rsp_if.
module hbr_back #(
  parameter int unsigned MAX_STATES = 8,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hbr_pkg::entry_t  head_i,
  input  logic             empty_i,
  output logic             pop_o,
  hbr_rsp_if.source        rsp
);

  localparam int unsigned SW     = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int unsigned TW     = (MAX_STATES > 1) ? $clog2(MAX_STATES * MAX_STATES) : 1;
  localparam int unsigned AB_W   = 34 - FRAC_BITS;
  localparam int unsigned TERM_W = AB_W + 32 - FRAC_BITS;
  localparam int unsigned ACC_A  = TERM_W + SW + 1;
  localparam int unsigned ACC_W  = (ACC_A > FRAC_BITS + 1) ? ACC_A : FRAC_BITS + 1;
  localparam int unsigned SAT_W  = (ACC_W > 32) ? ACC_W : 32;
  localparam logic [31:0] ONE    = 32'(1) << FRAC_BITS;

  // stores
  logic [16:0] trans_mem [MAX_STATES * MAX_STATES];
  logic [16:0] emis_mem  [MAX_STATES];
  logic [31:0] beta_mem  [2][MAX_STATES];

  hbr_pkg::state_e st_q;
  logic [SW-1:0]   i_q, j_q;
  logic            bank_q, upd_q, sc_en_q;
  logic [6:0]      n_q;
  logic [31:0]     scale_q, val_q;
  logic [hbr_pkg::SUM_W-1:0] sum_q, sum_nx;

  // pipeline
  logic              p1_v_q, p1_l_q, p2_v_q, p2_l_q, p3_v_q, p3_l_q;
  logic [16:0]       a_rd_q, b_rd_q;
  logic [31:0]       be_rd_q, be2_q;
  logic [33:0]       prod1;
  logic [AB_W-1:0]   ab_q;
  logic [AB_W+31:0]  prod2;
  logic [TERM_W-1:0] term_q;
  logic [ACC_W-1:0]  acc_q;
  logic              done_q;

  logic [TW-1:0]     waddr, raddr;
  logic              issue, j_last, i_last, out_free, put_fire, acc_clr;
  logic              div_start, div_done;
  logic [ACC_W-1:0]  div_num;
  logic [31:0]       div_den, div_quo, acc_sat;

  assign pop_o    = (st_q == hbr_pkg::ST_IDLE) && !empty_i;
  assign issue    = (st_q == hbr_pkg::ST_ISSUE);
  assign j_last   = (7'(j_q) == (n_q - 7'd1));
  assign i_last   = (7'(i_q) == (n_q - 7'd1));
  assign out_free = !rsp.valid || rsp.ready;
  assign put_fire = (st_q == hbr_pkg::ST_PUT) && out_free;
  assign sum_nx   = sum_q + hbr_pkg::SUM_W'(val_q);

  assign waddr = TW'(TW'(head_i.row) * TW'(MAX_STATES) + TW'(head_i.col));
  assign raddr = TW'(TW'(i_q) * TW'(MAX_STATES) + TW'(j_q));

  assign acc_sat = (SAT_W'(acc_q) > SAT_W'(hbr_pkg::SAT32)) ? hbr_pkg::SAT32 : 32'(acc_q);

  assign acc_clr = (pop_o && (head_i.cmd == hbr_pkg::REQ_EMIT) && head_i.fin) ||
                   (put_fire && !i_last && upd_q);

  assign div_start = (pop_o && (head_i.cmd == hbr_pkg::REQ_START) && head_i.scale_en) ||
                     ((st_q == hbr_pkg::ST_DRAIN) && done_q && sc_en_q);
  assign div_num   = (st_q == hbr_pkg::ST_DRAIN) ? acc_q : ACC_W'(ONE);
  assign div_den   = (st_q == hbr_pkg::ST_DRAIN) ? scale_q : head_i.scale;

  hbr_div #(
    .ACC_W     (ACC_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign prod1 = 34'(a_rd_q) * 34'(b_rd_q);
  assign prod2 = (AB_W+32)'(ab_q) * (AB_W+32)'(be2_q);

  // memories and product pipeline
  always_ff @(posedge clk_i) begin
    if (pop_o && (head_i.cmd == hbr_pkg::REQ_LOAD)) begin
      trans_mem[waddr] <= head_i.prob;
    end
    if (pop_o && (head_i.cmd == hbr_pkg::REQ_EMIT)) begin
      emis_mem[SW'(head_i.col)] <= head_i.prob;
    end
    if (put_fire) begin
      beta_mem[~bank_q][i_q] <= val_q;
    end
    a_rd_q  <= trans_mem[raddr];
    b_rd_q  <= emis_mem[j_q];
    be_rd_q <= beta_mem[bank_q][j_q];
    ab_q    <= prod1[33:FRAC_BITS];
    be2_q   <= be_rd_q;
    term_q  <= prod2[AB_W+31:FRAC_BITS];
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (put_fire) begin
      rsp.state_index <= 6'(i_q);
      rsp.beta_value  <= val_q;
      rsp.last        <= i_last;
      if (i_last) begin
        rsp.prob_sum <= (sum_nx > hbr_pkg::SUM_W'(hbr_pkg::SAT32)) ?
                        hbr_pkg::SAT32 : sum_nx[31:0];
      end else begin
        rsp.prob_sum <= 32'd0;
      end
    end
  end

  // hold or drop the result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp.valid <= 1'b0;
    end else if (put_fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // pipeline valids and accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0; p1_l_q <= 1'b0;
      p2_v_q <= 1'b0; p2_l_q <= 1'b0;
      p3_v_q <= 1'b0; p3_l_q <= 1'b0;
      done_q <= 1'b0;
      acc_q  <= '0;
    end else begin
      p1_v_q <= issue;
      p1_l_q <= issue && j_last;
      p2_v_q <= p1_v_q; p2_l_q <= p1_l_q;
      p3_v_q <= p2_v_q; p3_l_q <= p2_l_q;
      if (acc_clr) begin
        acc_q  <= '0;
        done_q <= 1'b0;
      end else if (p3_v_q) begin
        acc_q <= acc_q + ACC_W'(term_q);
        if (p3_l_q) done_q <= 1'b1;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= hbr_pkg::ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      bank_q  <= 1'b0;
      upd_q   <= 1'b0;
      sc_en_q <= 1'b0;
      n_q     <= 7'd1;
      scale_q <= ONE;
      val_q   <= '0;
      sum_q   <= '0;
    end else begin
      unique case (st_q)
        hbr_pkg::ST_IDLE: begin
          if (pop_o) begin
            i_q     <= '0;
            j_q     <= '0;
            sum_q   <= '0;
            n_q     <= head_i.n;
            sc_en_q <= head_i.scale_en;
            unique case (head_i.cmd)
              hbr_pkg::REQ_START: begin
                scale_q <= head_i.scale;
                upd_q   <= 1'b0;
                if (head_i.scale_en) begin
                  st_q <= hbr_pkg::ST_DIV;
                end else begin
                  val_q <= ONE;
                  st_q  <= hbr_pkg::ST_PUT;
                end
              end
              hbr_pkg::REQ_EMIT: begin
                scale_q <= head_i.scale;
                if (head_i.fin) begin
                  upd_q <= 1'b1;
                  st_q  <= hbr_pkg::ST_ISSUE;
                end
              end
              hbr_pkg::REQ_LOAD: st_q <= hbr_pkg::ST_IDLE;
              hbr_pkg::REQ_NONE: st_q <= hbr_pkg::ST_IDLE;
              default:           st_q <= hbr_pkg::ST_IDLE;
            endcase
          end
        end
        hbr_pkg::ST_ISSUE: begin
          j_q <= j_q + 1'b1;
          if (j_last) st_q <= hbr_pkg::ST_DRAIN;
        end
        hbr_pkg::ST_DRAIN: begin
          if (done_q) begin
            if (sc_en_q) begin
              st_q <= hbr_pkg::ST_DIV;
            end else begin
              val_q <= acc_sat;
              st_q  <= hbr_pkg::ST_PUT;
            end
          end
        end
        hbr_pkg::ST_DIV: begin
          if (div_done) begin
            val_q <= div_quo;
            st_q  <= hbr_pkg::ST_PUT;
          end
        end
        hbr_pkg::ST_PUT: begin
          if (out_free) begin
            sum_q <= sum_nx;
            if (i_last) begin
              bank_q <= ~bank_q;
              st_q   <= hbr_pkg::ST_IDLE;
            end else begin
              i_q <= i_q + 1'b1;
              if (upd_q) begin
                j_q  <= '0;
                st_q <= hbr_pkg::ST_ISSUE;
              end
            end
          end
        end
        default: st_q <= hbr_pkg::ST_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/hmm_backward_recursion.sv
// Load beats, and emission beats other than the last one of a vector, retire one per
// cycle from the queue while the back end is idle. A start beat goes straight to the
// results when scaling is off and through the divider first when it is on. A vector
// update runs, for each state, a pass through the single MAC pipe and, when scaling
// is on, the bit-serial divider. Reset: num_states 8, scaling on; the transition,
// beta and emission stores hold no reset value and need no clearing pass.
module hmm_backward_recursion #(
  parameter int unsigned MAX_STATES = 8,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [6:0] cfg_data_i,
  hbr_req_if.sink    req,
  hbr_rsp_if.source  rsp
);

  logic [6:0]      num_states_q;
  logic            scaling_q;
  logic            push, full, pop, empty;
  hbr_pkg::entry_t entry_in, entry_out;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_states_q <= hbr_pkg::NUM_STATES_RST;
      scaling_q    <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        hbr_pkg::CFG_NUM_STATES: num_states_q <= cfg_data_i;
        hbr_pkg::CFG_SCALING:    scaling_q    <= cfg_data_i[0];
        default:                 scaling_q    <= scaling_q;
      endcase
    end
  end

  hbr_front #(
    .MAX_STATES (MAX_STATES)
  ) u_front (
    .req          (req),
    .num_states_i (num_states_q),
    .scaling_i    (scaling_q),
    .full_i       (full),
    .push_o       (push),
    .entry_o      (entry_in)
  );

  hbr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (entry_in),
    .full_o  (full),
    .pop_i   (pop),
    .dout_o  (entry_out),
    .empty_o (empty)
  );

  hbr_back #(
    .MAX_STATES (MAX_STATES),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (entry_out),
    .empty_i (empty),
    .pop_o   (pop),
    .rsp     (rsp)
  );

endmodule

FILE: sv/hbr_checker.sv
// hbr_checker: port-level assertions on the result channel, bound to the top level.
// Depends on hmm_backward_recursion.
module hbr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [5:0]  state_index_i,
  input logic [31:0] beta_value_i,
  input logic [31:0] prob_sum_i,
  input logic        last_i
);

  logic [5:0] exp_q;

  // track the state index the next result must carry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= '0;
    end else if (rsp_valid_i && rsp_ready_i) begin
      exp_q <= last_i ? 6'd0 : state_index_i + 6'd1;
    end
  end

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(beta_value_i) && $stable(state_index_i))
    else $error("result payload changed while stalled");

  a_sum_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !last_i |-> prob_sum_i == 32'd0)
    else $error("sum shown on a non-final result");

  a_index_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> state_index_i == exp_q)
    else $error("results out of state order");

endmodule

bind hmm_backward_recursion hbr_checker u_hbr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp.valid),
  .rsp_ready_i   (rsp.ready),
  .state_index_i (rsp.state_index),
  .beta_value_i  (rsp.beta_value),
  .prob_sum_i    (rsp.prob_sum),
  .last_i        (rsp.last)
);

FILE: tb/tb.sv
// tb: self-checking testbench of hmm_backward_recursion, a scaled HMM backward pass.
// Depends on hbr_pkg, hbr_req_if, hbr_rsp_if and the block itself; predicts every
// result beat in Q16.16 and compares it field by field.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned NMAX     = 8;
  localparam int unsigned FRAC     = 16;
  localparam logic [31:0] ONE_Q    = 32'h0001_0000;
  localparam int unsigned SETTLE   = 600;
  localparam int unsigned LIMIT    = 4000000;
  localparam int unsigned ITEMS    = 330;

  typedef struct packed {
    logic [5:0]  state;
    logic [31:0] beta;
    logic [31:0] sum;
    logic        last;
  } beta_beat_t;

  typedef struct packed {
    hbr_pkg::req_e req;
    logic [5:0]  row;
    logic [5:0]  col;
    logic [16:0] prob;
    logic [31:0] scale;
    logic        has_exp;
    logic [31:0] exp_beta;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [6:0] cfg_data_i = '0;

  hbr_req_if req_if ();
  hbr_rsp_if rsp_if ();

  hmm_backward_recursion u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_if),
    .rsp        (rsp_if)
  );

  // clock, 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow of the block state
  logic [16:0] trans_q [NMAX][NMAX];
  logic [31:0] beta_q [NMAX];
  logic [16:0] emis_q [NMAX];
  logic [NMAX-1:0] emis_seen;
  logic [31:0] scale_q;
  logic [6:0]  num_states_q;
  logic        scaling_q;
  logic [31:0] first_beta;

  beta_beat_t beta_exp_q [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit idle_on = 1'b1;

  function automatic int unsigned states_used();
    if (num_states_q == 0) return 1;
    if (num_states_q > NMAX) return NMAX;
    return num_states_q;
  endfunction

  // floor(num * 2^FRAC / den), saturated
  function automatic logic [31:0] fx_quot(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] res;
    if (den == 0) return hbr_pkg::SAT32;
    q = num / den;
    r = num % den;
    if (q >= (64'd1 << (32 - FRAC))) return hbr_pkg::SAT32;
    res = (q << FRAC) + ((r << FRAC) / den);
    return (res > {32'd0, hbr_pkg::SAT32}) ? hbr_pkg::SAT32 : res[31:0];
  endfunction

  function automatic void push_vector(int unsigned n);
    logic [63:0] total;
    beta_beat_t b;
    total = '0;
    first_beta = beta_q[0];
    for (int unsigned i = 0; i < n; i++) begin
      total += beta_q[i];
      b.state = i[5:0];
      b.beta  = beta_q[i];
      b.sum   = '0;
      b.last  = 1'b0;
      if (i == n - 1) begin
        b.sum  = (total > {32'd0, hbr_pkg::SAT32}) ? hbr_pkg::SAT32 : total[31:0];
        b.last = 1'b1;
      end
      beta_exp_q.push_back(b);
    end
  endfunction

  // advance the shadow state by one accepted request beat
  function automatic void backward_step(hbr_pkg::req_e req, logic [5:0] row,
                                        logic [5:0] col, logic [16:0] prob,
                                        logic [31:0] scale);
    int unsigned n;
    logic [63:0] acc;
    logic [63:0] ab;
    logic [31:0] nxt [NMAX];
    n = states_used();
    case (req)
      hbr_pkg::REQ_LOAD: begin
        if (row < NMAX && col < NMAX) trans_q[row][col] = prob;
      end
      hbr_pkg::REQ_START: begin
        scale_q = scale;
        for (int unsigned i = 0; i < n; i++)
          beta_q[i] = scaling_q ? fx_quot(64'(ONE_Q), 64'(scale)) : ONE_Q;
        push_vector(n);
      end
      hbr_pkg::REQ_EMIT: begin
        if (col < n) begin
          emis_q[col] = prob;
          emis_seen[col] = 1'b1;
          scale_q = scale;
          if (col == n - 1) begin
            for (int unsigned i = 0; i < n; i++) begin
              acc = '0;
              for (int unsigned j = 0; j < n; j++) begin
                ab = (64'(trans_q[i][j]) * 64'(emis_q[j])) >> FRAC;
                acc += (ab * 64'(beta_q[j])) >> FRAC;
              end
              if (scaling_q) nxt[i] = fx_quot(acc, 64'(scale_q));
              else nxt[i] = (acc > {32'd0, hbr_pkg::SAT32}) ? hbr_pkg::SAT32 : acc[31:0];
            end
            for (int unsigned i = 0; i < n; i++) beta_q[i] = nxt[i];
            push_vector(n);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // drive one request beat and hold it until accepted
  task automatic send_beat(hbr_pkg::req_e req, logic [5:0] row, logic [5:0] col,
                           logic [16:0] prob, logic [31:0] scale);
    int unsigned gap;
    gap = gap_len();
    repeat (gap) @(negedge clk_i) req_if.valid = 1'b0;
    @(negedge clk_i);
    req_if.valid       = 1'b1;
    req_if.req_type    = req;
    req_if.row_index   = row;
    req_if.col_index   = col;
    req_if.prob_value  = prob;
    req_if.scale_value = scale;
    do @(posedge clk_i); while (!req_if.ready);
    backward_step(req, row, col, prob, scale);
  endtask

  task automatic end_burst();
    @(negedge clk_i) req_if.valid = 1'b0;
  endtask

  // drain results, then let the block settle before touching a register
  task automatic wait_quiet();
    end_burst();
    while (beta_exp_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [6:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(negedge clk_i) cfg_we_i = 1'b0;
    if (idx == hbr_pkg::CFG_NUM_STATES) num_states_q = data;
    else scaling_q = data[0];
  endtask

  function automatic logic [31:0] rand_scale();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return $urandom_range(32'h0000_8000, 32'h0002_0000);
  endfunction

  // emission for col, first filling any lower slot never written
  task automatic send_emit(logic [5:0] col, logic [31:0] scale);
    if (col == states_used() - 1) begin
      for (int unsigned j = 0; j + 1 < states_used(); j++)
        if (!emis_seen[j])
          send_beat(hbr_pkg::REQ_EMIT, '0, j[5:0], 17'($urandom_range(0, 65536)), scale);
    end
    send_beat(hbr_pkg::REQ_EMIT, 6'($urandom()), col, 17'($urandom_range(0, 65536)),
              scale);
  endtask

  // result side: random stalls on ready
  initial begin
    int unsigned stall;
    stall = 0;
    rsp_if.ready = 1'b0;
    forever @(negedge clk_i) begin
      if (stall > 0) begin
        rsp_if.ready = 1'b0;
        stall--;
      end else begin
        rsp_if.ready = 1'b1;
        stall = gap_len();
      end
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    beta_beat_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (beta_exp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat state %0d beta %h",
                                       rsp_if.state_index, rsp_if.beta_value);
      end else begin
        want = beta_exp_q.pop_front();
        if (rsp_if.state_index !== want.state || rsp_if.beta_value !== want.beta ||
            rsp_if.prob_sum !== want.sum || rsp_if.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %h %h %b, got %0d %h %h %b",
                     want.state, want.beta, want.sum, want.last, rsp_if.state_index,
                     rsp_if.beta_value, rsp_if.prob_sum, rsp_if.last);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL hmm_backward_recursion");
      $finish;
    end
  end

  stim_row_t dir_tab [] = '{
    '{hbr_pkg::REQ_START, 6'd0,  6'd0,  17'd0,     32'h0001_0000, 1'b1, 32'h0001_0000},
    '{hbr_pkg::REQ_START, 6'd0,  6'd0,  17'd0,     32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
    '{hbr_pkg::REQ_START, 6'd0,  6'd0,  17'd0,     32'hFFFF_FFFF, 1'b1, 32'h0000_0001},
    '{hbr_pkg::REQ_START, 6'd0,  6'd0,  17'd0,     32'h0002_0000, 1'b1, 32'h0000_8000},
    '{hbr_pkg::REQ_LOAD,  6'd63, 6'd0,  17'h1FFFF, 32'd0,         1'b0, 32'd0},
    '{hbr_pkg::REQ_LOAD,  6'd0,  6'd63, 17'h1FFFF, 32'd0,         1'b0, 32'd0},
    '{hbr_pkg::REQ_NONE,  6'd63, 6'd63, 17'h1FFFF, 32'hFFFF_FFFF, 1'b0, 32'd0},
    '{hbr_pkg::REQ_EMIT,  6'd0,  6'd63, 17'd65536, 32'h0001_0000, 1'b0, 32'd0},
    '{hbr_pkg::REQ_EMIT,  6'd0,  6'd0,  17'd65536, 32'h0001_0000, 1'b0, 32'd0},
    '{hbr_pkg::REQ_EMIT,  6'd0,  6'd1,  17'd65536, 32'h0001_0000, 1'b0, 32'd0},
    '{hbr_pkg::REQ_EMIT,  6'd0,  6'd2,  17'd0,     32'h0001_0000, 1'b0, 32'd0},
    '{hbr_pkg::REQ_EMIT,  6'd0,  6'd3,  17'd65536, 32'h0001_0000, 1'b0, 32'd0},
    '{hbr_pkg::REQ_EMIT,  6'd0,  6'd4,  17'd32768, 32'h0001_0000, 1'b0, 32'd0},
    '{hbr_pkg::REQ_EMIT,  6'd0,  6'd5,  17'd65536, 32'h0001_0000, 1'b0, 32'd0},
    '{hbr_pkg::REQ_EMIT,  6'd0,  6'd6,  17'd1,     32'h0001_0000, 1'b0, 32'd0},
    '{hbr_pkg::REQ_EMIT,  6'd0,  6'd7,  17'd65536, 32'h0001_0000, 1'b0, 32'd0},
    '{hbr_pkg::REQ_LOAD,  6'd0,  6'd0,  17'd0,     32'd0,         1'b0, 32'd0},
    '{hbr_pkg::REQ_LOAD,  6'd7,  6'd7,  17'd65536, 32'd0,         1'b0, 32'd0},
    '{hbr_pkg::REQ_EMIT,  6'd0,  6'd0,  17'd65536, 32'h0000_0000, 1'b0, 32'd0},
    '{hbr_pkg::REQ_EMIT,  6'd0,  6'd3,  17'd65536, 32'h0000_0000, 1'b0, 32'd0},
    '{hbr_pkg::REQ_EMIT,  6'd0,  6'd7,  17'd65536, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF},
    '{hbr_pkg::REQ_START, 6'd5,  6'd9,  17'd65536, 32'h0001_0000, 1'b1, 32'h0001_0000}
  };

  logic [6:0] phase_num [] = '{7'd8, 7'd1, 7'd0, 7'd127, 7'd3, 7'd64, 7'd5, 7'd8, 7'd2};
  logic       phase_scl [] = '{1'b1, 1'b0, 1'b1, 1'b0,   1'b1, 1'b1,  1'b0, 1'b0, 1'b1};

  initial begin
    int unsigned sent;
    int unsigned per_phase;
    int unsigned r;
    logic [5:0] c;
    req_if.valid = 1'b0;
    req_if.req_type = hbr_pkg::REQ_NONE;
    req_if.row_index = '0;
    req_if.col_index = '0;
    req_if.prob_value = '0;
    req_if.scale_value = '0;
    for (int i = 0; i < NMAX; i++) begin
      beta_q[i] = '0;
      emis_q[i] = '0;
      for (int j = 0; j < NMAX; j++) trans_q[i][j] = '0;
    end
    emis_seen = '0;
    scale_q = ONE_Q;
    num_states_q = hbr_pkg::NUM_STATES_RST;
    scaling_q = 1'b1;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // fill every transition entry before any update reads one
    for (int i = 0; i < NMAX; i++)
      for (int j = 0; j < NMAX; j++)
        send_beat(hbr_pkg::REQ_LOAD, i[5:0], j[5:0], 17'($urandom_range(0, 65536)), '0);

    // directed rows, reset configuration
    foreach (dir_tab[k]) begin
      send_beat(dir_tab[k].req, dir_tab[k].row, dir_tab[k].col, dir_tab[k].prob,
                dir_tab[k].scale);
      if (dir_tab[k].has_exp && first_beta !== dir_tab[k].exp_beta) begin
        mismatches++;
        if (mismatches <= 10) $display("table row %0d: exp beta %h, predicted %h",
                                       k, dir_tab[k].exp_beta, first_beta);
      end
    end

    // random phases over several register settings
    per_phase = (ITEMS - NMAX * NMAX - dir_tab.size()) / phase_num.size();
    foreach (phase_num[p]) begin
      wait_quiet();
      idle_on = (p % 3) != 2;
      write_cfg(hbr_pkg::CFG_NUM_STATES, phase_num[p]);
      write_cfg(hbr_pkg::CFG_SCALING, 7'(phase_scl[p]));
      send_beat(hbr_pkg::REQ_START, 6'($urandom()), 6'($urandom()), 17'($urandom()),
                rand_scale());
      sent = 0;
      while (sent < per_phase) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          // whole vector in state order
          for (int unsigned j = 0; j < states_used(); j++) send_emit(j[5:0], rand_scale());
          sent += states_used();
        end else if (r < 70) begin
          send_beat(hbr_pkg::REQ_LOAD, 6'($urandom_range(0, 9)), 6'($urandom_range(0, 9)),
                    17'($urandom_range(0, 65536)), $urandom());
          sent++;
        end else if (r < 80) begin
          c = 6'($urandom_range(0, states_used() - 1));
          send_emit(c, rand_scale());
          sent++;
        end else if (r < 86) begin
          send_beat(hbr_pkg::REQ_START, 6'($urandom()), 6'($urandom()), 17'($urandom()),
                    rand_scale());
          sent++;
        end else if (r < 93) begin
          send_beat(hbr_pkg::REQ_EMIT, 6'($urandom()),
                    6'($urandom_range(states_used(), 63)), 17'($urandom()), $urandom());
          sent++;
        end else begin
          send_beat(hbr_pkg::REQ_NONE, 6'($urandom()), 6'($urandom()), 17'($urandom()),
                    $urandom());
          sent++;
        end
      end
    end

    wait_quiet();
    if (mismatches == 0) $display("PASS hmm_backward_recursion");
    else $display("FAIL hmm_backward_recursion");
    $finish;
  end

endmodule
